FILE: rtl/core/tbhu_pkg.sv
// Shared widths, register indexes and defaults for the terrain brush height update block.
package tbhu_pkg;

  localparam int COORD_W       = 24;
  localparam int RADIUS_W      = 16;
  localparam int STRENGTH_W    = 16;
  localparam int DIR_W         = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int SQ_W          = 2 * DIFF_W;
  localparam int D2_W          = SQ_W + 2;
  localparam int ROOT_W        = D2_W / 2;
  localparam int INC_W         = STRENGTH_W + 1;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [RADIUS_W-1:0]   RADIUS_RST   = 16'd1280;
  localparam logic [STRENGTH_W-1:0] STRENGTH_RST = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRUSH_X  = 3'd0,
    CFG_BRUSH_Z  = 3'd1,
    CFG_CURSOR_X = 3'd2,
    CFG_CURSOR_Z = 3'd3,
    CFG_RADIUS   = 3'd4,
    CFG_STRENGTH = 3'd5,
    CFG_DIR      = 3'd6
  } cfg_idx_t;

  localparam logic [DIR_W-1:0] DIR_NONE  = 2'b00;
  localparam logic [DIR_W-1:0] DIR_RAISE = 2'b01;
  localparam logic [DIR_W-1:0] DIR_LOW2  = 2'b10;
  localparam logic [DIR_W-1:0] DIR_LOWER = 2'b11;

endpackage

FILE: rtl/core/tbhu_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module tbhu_sqrt #(
  parameter int IN_W  = tbhu_pkg::D2_W,
  parameter int TAG_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [IN_W-1:0]      in_rad,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  output logic [IN_W/2-1:0]    out_root,
  output logic [TAG_W-1:0]     out_tag
);

  localparam int RW    = IN_W / 2;
  localparam int REM_W = RW + 3;

  logic [IN_W-1:0]  n_r    [0:RW-1];
  logic [REM_W-1:0] rem_r  [0:RW-1];
  logic [RW-1:0]    root_r [0:RW-1];
  logic [TAG_W-1:0] tag_r  [0:RW-1];
  logic [RW-1:0]    v_r;

  wire [IN_W-1:0]  n_s    [0:RW-1];
  wire [REM_W-1:0] rem_s  [0:RW-1];
  wire [RW-1:0]    root_s [0:RW-1];
  wire [TAG_W-1:0] tag_s  [0:RW-1];
  wire [RW-1:0]    v_s;

  genvar k;
  generate
    for (k = 0; k < RW; k++) begin : g_stage
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             ge;

      // stage source: module inputs or previous stage
      if (k == 0) begin : g_src_in
        assign n_s[k]    = in_rad;
        assign rem_s[k]  = '0;
        assign root_s[k] = '0;
        assign tag_s[k]  = in_tag;
        assign v_s[k]    = in_valid;
      end else begin : g_src_prev
        assign n_s[k]    = n_r[k-1];
        assign rem_s[k]  = rem_r[k-1];
        assign root_s[k] = root_r[k-1];
        assign tag_s[k]  = tag_r[k-1];
        assign v_s[k]    = v_r[k-1];
      end

      // bring down two radicand bits, try root*4+1
      always_comb begin
        rem_sh = {rem_s[k][REM_W-3:0], n_s[k][IN_W-1 -: 2]};
        trial  = {1'b0, root_s[k], 2'b01};
        ge     = (rem_sh >= trial);
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_s[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          n_r[k]    <= {n_s[k][IN_W-3:0], 2'b00};
          rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
          root_r[k] <= {root_s[k][RW-2:0], ge};
          tag_r[k]  <= tag_s[k];
        end
      end
    end
  endgenerate

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_tag   = tag_r[RW-1];

endmodule

FILE: rtl/core/tbhu_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module tbhu_div #(
  parameter int NUM_W = tbhu_pkg::STRENGTH_W + tbhu_pkg::FRAC_BITS_DEF,
  parameter int DEN_W = tbhu_pkg::ROOT_W,
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [TAG_W-1:0]  out_tag
);

  logic [NUM_W-1:0] num_r [0:NUM_W-1];
  logic [DEN_W-1:0] den_r [0:NUM_W-1];
  logic [DEN_W-1:0] rem_r [0:NUM_W-1];
  logic [NUM_W-1:0] quo_r [0:NUM_W-1];
  logic [TAG_W-1:0] tag_r [0:NUM_W-1];
  logic [NUM_W-1:0] v_r;

  wire [NUM_W-1:0] num_s [0:NUM_W-1];
  wire [DEN_W-1:0] den_s [0:NUM_W-1];
  wire [DEN_W-1:0] rem_s [0:NUM_W-1];
  wire [NUM_W-1:0] quo_s [0:NUM_W-1];
  wire [TAG_W-1:0] tag_s [0:NUM_W-1];
  wire [NUM_W-1:0] v_s;

  genvar k;
  generate
    for (k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W:0] rem_sh;
      logic           ge;

      if (k == 0) begin : g_src_in
        assign num_s[k] = in_num;
        assign den_s[k] = in_den;
        assign rem_s[k] = '0;
        assign quo_s[k] = '0;
        assign tag_s[k] = in_tag;
        assign v_s[k]   = in_valid;
      end else begin : g_src_prev
        assign num_s[k] = num_r[k-1];
        assign den_s[k] = den_r[k-1];
        assign rem_s[k] = rem_r[k-1];
        assign quo_s[k] = quo_r[k-1];
        assign tag_s[k] = tag_r[k-1];
        assign v_s[k]   = v_r[k-1];
      end

      // shift in next numerator bit, subtract divisor if it fits
      always_comb begin
        rem_sh = {rem_s[k], num_s[k][NUM_W-1]};
        ge     = (rem_sh >= {1'b0, den_s[k]});
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_s[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          num_r[k] <= {num_s[k][NUM_W-2:0], 1'b0};
          den_r[k] <= den_s[k];
          rem_r[k] <= ge ? DEN_W'(rem_sh - {1'b0, den_s[k]}) : rem_sh[DEN_W-1:0];
          quo_r[k] <= {quo_s[k][NUM_W-2:0], ge};
          tag_r[k] <= tag_s[k];
        end
      end
    end
  endgenerate

  assign out_valid = v_r[NUM_W-1];
  assign out_quo   = quo_r[NUM_W-1];
  assign out_tag   = tag_r[NUM_W-1];

endmodule

FILE: rtl/core/terrain_brush_height_update.sv
// Top level of the terrain brush height update pipeline.
//
//  channel | dir | handshake          | word
//  in_     | in  | in_tvalid/tready   | tdata: vertex_x, vertex_z, vertex_height
//  out_    | out | out_tvalid/tready  | tdata: new_height; tuser: in_window, clipped
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data (register write)
//
// One vertex per cycle while out_ is not stalled; the root and divide units retire
// one bit per stage.
// Reset clears all valid bits and loads register defaults; no clearing pass.
// A stall at out_ freezes the whole pipeline; in_tready follows it directly.
// cfg_ready is always high.
module terrain_brush_height_update #(
  parameter int COORD_FRAC_BITS = tbhu_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [23:0] vertex_x, [47:24] vertex_z, [71:48] vertex_height
  input  logic [3*tbhu_pkg::COORD_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [23:0] new_height
  output logic [tbhu_pkg::COORD_W-1:0]    out_tdata,
  // [0] in_window, [1] clipped
  output logic [1:0]                      out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tbhu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbhu_pkg::COORD_W-1:0]    cfg_data
);

  localparam int CW    = tbhu_pkg::COORD_W;
  localparam int DW    = tbhu_pkg::DIFF_W;
  localparam int RW    = tbhu_pkg::ROOT_W;
  localparam int NUM_W = tbhu_pkg::STRENGTH_W + COORD_FRAC_BITS;
  localparam int TAG_W = CW + 1;
  localparam int IW    = tbhu_pkg::INC_W;
  localparam logic [RW-1:0] ONE = RW'(1) << COORD_FRAC_BITS;

  // configuration registers
  logic signed [CW-1:0]                 brush_x_r, brush_z_r, cursor_x_r, cursor_z_r;
  logic [tbhu_pkg::RADIUS_W-1:0]        radius_r;
  logic [tbhu_pkg::STRENGTH_W-1:0]      strength_r;
  logic [tbhu_pkg::DIR_W-1:0]           dir_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brush_x_r  <= '0;
      brush_z_r  <= '0;
      cursor_x_r <= '0;
      cursor_z_r <= '0;
      radius_r   <= tbhu_pkg::RADIUS_RST;
      strength_r <= tbhu_pkg::STRENGTH_RST;
      dir_r      <= tbhu_pkg::DIR_NONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tbhu_pkg::CFG_BRUSH_X:  brush_x_r  <= cfg_data;
        tbhu_pkg::CFG_BRUSH_Z:  brush_z_r  <= cfg_data;
        tbhu_pkg::CFG_CURSOR_X: cursor_x_r <= cfg_data;
        tbhu_pkg::CFG_CURSOR_Z: cursor_z_r <= cfg_data;
        tbhu_pkg::CFG_RADIUS:   radius_r   <= cfg_data[tbhu_pkg::RADIUS_W-1:0];
        tbhu_pkg::CFG_STRENGTH: strength_r <= cfg_data[tbhu_pkg::STRENGTH_W-1:0];
        tbhu_pkg::CFG_DIR:      dir_r      <= cfg_data[tbhu_pkg::DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: whole pipe moves unless the output word is held
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: differences, magnitudes, window test
  logic signed [CW-1:0] vx, vz, vh;
  logic signed [DW-1:0] wx, wz, dx, dz;
  logic [DW-1:0]        awx, awz, adx, adz;
  logic                 in_win;

  always_comb begin
    vx  = in_tdata[CW-1:0];
    vz  = in_tdata[2*CW-1:CW];
    vh  = in_tdata[3*CW-1:2*CW];
    wx  = DW'(brush_x_r) - DW'(vx);
    wz  = DW'(brush_z_r) - DW'(vz);
    dx  = DW'(cursor_x_r) - DW'(vx);
    dz  = DW'(cursor_z_r) - DW'(vz);
    awx = wx[DW-1] ? DW'(-wx) : wx;
    awz = wz[DW-1] ? DW'(-wz) : wz;
    adx = dx[DW-1] ? DW'(-dx) : dx;
    adz = dz[DW-1] ? DW'(-dz) : dz;
    in_win = (awx <= DW'(radius_r)) && (awz <= DW'(radius_r));
  end

  logic              s1_v_r;
  logic [DW-1:0]     s1_adx_r, s1_adz_r;
  logic [TAG_W-1:0]  s1_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_adx_r <= adx;
      s1_adz_r <= adz;
      s1_tag_r <= {in_win, vh};
    end
  end

  // stage 2: squares
  logic                        s2_v_r;
  logic [tbhu_pkg::SQ_W-1:0]   s2_sqx_r, s2_sqz_r;
  logic [TAG_W-1:0]            s2_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sqx_r <= s1_adx_r * s1_adx_r;
      s2_sqz_r <= s1_adz_r * s1_adz_r;
      s2_tag_r <= s1_tag_r;
    end
  end

  // stage 3: squared distance
  logic                        s3_v_r;
  logic [tbhu_pkg::D2_W-1:0]   s3_d2_r;
  logic [TAG_W-1:0]            s3_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d2_r  <= tbhu_pkg::D2_W'(s2_sqx_r) + tbhu_pkg::D2_W'(s2_sqz_r);
      s3_tag_r <= s2_tag_r;
    end
  end

  // distance
  logic             sq_v;
  logic [RW-1:0]    sq_root;
  logic [TAG_W-1:0] sq_tag;

  tbhu_sqrt #(
    .IN_W  (tbhu_pkg::D2_W),
    .TAG_W (TAG_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_rad    (s3_d2_r),
    .in_tag    (s3_tag_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // clamp distance to one, then strength / distance
  logic [RW-1:0]    mag;
  logic [NUM_W-1:0] num;
  assign mag = (sq_root < ONE) ? ONE : sq_root;
  assign num = {strength_r, {COORD_FRAC_BITS{1'b0}}};

  logic             dv_v;
  logic [NUM_W-1:0] dv_quo;
  logic [TAG_W-1:0] dv_tag;

  tbhu_div #(
    .NUM_W (NUM_W),
    .DEN_W (RW),
    .TAG_W (TAG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .in_num    (num),
    .in_den    (mag),
    .in_tag    (sq_tag),
    .out_valid (dv_v),
    .out_quo   (dv_quo),
    .out_tag   (dv_tag)
  );

  // final: apply direction, add, saturate inside the window; else keep the old height
  localparam int SUM_W = CW + 2;
  logic [IW-1:0]          inc;
  logic signed [IW+1:0]   term;
  logic signed [SUM_W-1:0] sum;
  logic signed [CW-1:0]   h_old, h_new;
  logic                   d_in, clip;

  always_comb begin
    inc   = dv_quo[IW-1:0];
    h_old = dv_tag[CW-1:0];
    d_in  = dv_tag[CW];
    unique case (dir_r)
      tbhu_pkg::DIR_NONE:  term = '0;
      tbhu_pkg::DIR_RAISE: term = $signed({2'b00, inc});
      tbhu_pkg::DIR_LOWER: term = -$signed({2'b00, inc});
      tbhu_pkg::DIR_LOW2:  term = -$signed({1'b0, inc, 1'b0});
      default:             term = '0;
    endcase
    sum   = SUM_W'(h_old) + SUM_W'(term);
    clip  = 1'b0;
    h_new = h_old;
    if (d_in) begin
      if (sum > SUM_W'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
        h_new = {1'b0, {(CW-1){1'b1}}};
        clip  = 1'b1;
      end else if (sum < SUM_W'(signed'({1'b1, {(CW-1){1'b0}}}))) begin
        h_new = {1'b1, {(CW-1){1'b0}}};
        clip  = 1'b1;
      end else begin
        h_new = sum[CW-1:0];
      end
    end
  end

  // output register
  logic          out_v_r;
  logic [CW-1:0] out_h_r;
  logic [1:0]    out_u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_h_r <= h_new;
      out_u_r <= {clip, d_in};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_h_r;
  assign out_tuser  = out_u_r;

  // checks
  a_clip_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && !out_tuser[0]))
    else $error("clipped set outside window");

  a_no_clip_idle_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && dir_r == tbhu_pkg::DIR_NONE |-> !out_tuser[1])
    else $error("clipped with no tool direction");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(dv_v) && $stable(s1_v_r))
    else $error("pipeline moved during stall");

endmodule
